[hdl/assert_macros.svh]
// assertion helpers for the calculator block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// checked property with reset masking
`define KCC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked property that also holds through reset
`define KCC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define KCC_ASSERT(lbl, clk, rst, prop, msg)
`define KCC_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

[hdl/kcc_pkg.sv]
// ----------------------------------------------------------------------------
// kcc_pkg
// Shared key codes, operator codes and unit control types for the
// keypad calculator core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kcc_pkg;

   localparam int OUT_WIDTH = 32;

   typedef enum logic [2:0] {
      KEY_DIGIT    = 3'd0,
      KEY_OPER     = 3'd1,
      KEY_EQUALS   = 3'd2,
      KEY_MADD     = 3'd3,
      KEY_MCLEAR   = 3'd4,
      KEY_MRECALL  = 3'd5,
      KEY_ALLCLEAR = 3'd6
   } key_type;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      PEND_NONE = 3'd0,
      PEND_ADD  = 3'd1,
      PEND_SUB  = 3'd2,
      PEND_MUL  = 3'd3,
      PEND_DIV  = 3'd4
   } pend_type;

   // control from the sequencer to the shared multiply/divide unit
   typedef struct packed {
      logic start;
      logic is_div;
   } unit_ctl_type;

   function automatic pend_type pend_of_op(input logic [1:0] opc);
      pend_type p;
      case (opc)
         OP_ADD:  p = PEND_ADD;
         OP_SUB:  p = PEND_SUB;
         OP_MUL:  p = PEND_MUL;
         default: p = PEND_DIV;
      endcase
      return p;
   endfunction

endpackage

`default_nettype wire

[hdl/kcc_muldiv.sv]
// ----------------------------------------------------------------------------
// kcc_muldiv
// Iterative multiply / signed divide around one shared add/subtract unit,
// one bit per cycle. Product keeps the low bits; quotient truncates to zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kcc_muldiv #(
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire kcc_pkg::unit_ctl_type    ctl,
   input  wire logic [DATA_WIDTH-1:0]    opnd_a,
   input  wire logic [DATA_WIDTH-1:0]    opnd_b,
   output logic                          done,
   output logic [DATA_WIDTH-1:0]         result
);

   localparam int CNT_W = $clog2(DATA_WIDTH);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_WIDTH - 1);

   typedef enum logic [2:0] {
      U_IDLE = 3'b001,
      U_RUN  = 3'b010,
      U_FIN  = 3'b100
   } ustate_type;

   ustate_type            state_ff, state_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DATA_WIDTH-1:0] acc_ff, acc_in;
   logic [DATA_WIDTH-1:0] opa_ff, opa_in;
   logic [DATA_WIDTH-1:0] opb_ff, opb_in;
   logic                  div_ff, div_in;
   logic                  neg_ff, neg_in;

   logic [DATA_WIDTH:0]   alu_x, alu_y, alu_out;
   logic [DATA_WIDTH-1:0] mag_a, mag_b;

   // shared adder: remainder trial subtract for divide, partial sum for multiply
   always_comb begin
      if (div_ff) begin
         alu_x   = {acc_ff, opb_ff[DATA_WIDTH-1]};
         alu_y   = {1'b0, opa_ff};
         alu_out = alu_x - alu_y;
      end else begin
         alu_x   = {1'b0, acc_ff};
         alu_y   = {1'b0, opa_ff};
         alu_out = alu_x + alu_y;
      end
   end

   assign mag_a = opnd_a[DATA_WIDTH-1] ? (DATA_WIDTH'(0) - opnd_a) : opnd_a;
   assign mag_b = opnd_b[DATA_WIDTH-1] ? (DATA_WIDTH'(0) - opnd_b) : opnd_b;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      opa_in   = opa_ff;
      opb_in   = opb_ff;
      div_in   = div_ff;
      neg_in   = neg_ff;
      unique case (state_ff)
         U_IDLE: begin
            if (ctl.start) begin
               state_in = U_RUN;
               cnt_in   = CNT_LAST;
               acc_in   = '0;
               div_in   = ctl.is_div;
               neg_in   = opnd_a[DATA_WIDTH-1] ^ opnd_b[DATA_WIDTH-1];
               if (ctl.is_div) begin
                  opa_in = mag_b;
                  opb_in = mag_a;
               end else begin
                  opa_in = opnd_a;
                  opb_in = opnd_b;
               end
            end
         end
         U_RUN: begin
            if (div_ff) begin
               // restoring step: keep the trial if it did not go negative
               if (!alu_out[DATA_WIDTH]) begin
                  acc_in = alu_out[DATA_WIDTH-1:0];
               end else begin
                  acc_in = alu_x[DATA_WIDTH-1:0];
               end
               opb_in = {opb_ff[DATA_WIDTH-2:0], ~alu_out[DATA_WIDTH]};
            end else begin
               if (opb_ff[0]) begin
                  acc_in = alu_out[DATA_WIDTH-1:0];
               end
               opa_in = {opa_ff[DATA_WIDTH-2:0], 1'b0};
               opb_in = {1'b0, opb_ff[DATA_WIDTH-1:1]};
            end
            if (cnt_ff == '0) begin
               state_in = U_FIN;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         U_FIN: begin
            state_in = U_IDLE;
         end
         default: begin
            state_in = U_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      opa_ff <= opa_in;
      opb_ff <= opb_in;
      div_ff <= div_in;
      neg_ff <= neg_in;
   end

   assign done = (state_ff == U_FIN);

   always_comb begin
      if (!div_ff) begin
         result = acc_ff;
      end else if (neg_ff) begin
         result = DATA_WIDTH'(0) - opb_ff;
      end else begin
         result = opb_ff;
      end
   end

endmodule

`default_nettype wire

[hdl/keypad_calculator_core.sv]
// ----------------------------------------------------------------------------
// keypad_calculator_core
// Four-function calculator with memory, one key word in, one status word out.
// ----------------------------------------------------------------------------
// Each key word is taken when the core is idle and answered with one word
// carrying display, memory and error flag. Digit, add, subtract, memory and
// clear keys pass through the execute state into the response register; a
// key that completes a pending multiply or divide first waits for the
// shared add/subtract unit, which retires one multiplier or quotient bit
// per cycle. A finished response waits in its output register, and the
// next key is taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module keypad_calculator_core #(
   parameter int DATA_WIDTH = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_mode,
   input  wire logic [3:0]  req_digit_value,
   input  wire logic [1:0]  req_operator_code,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic signed [31:0] rsp_display_value,
   output logic signed [31:0] rsp_memory_value,
   output logic             rsp_error_flag
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_EXEC = 4'b0010,
      S_WAIT = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   state_type             state_ff, state_in;
   logic [2:0]            mode_ff, mode_in;
   logic [3:0]            digit_ff, digit_in;
   logic [1:0]            opc_ff, opc_in;

   logic [DATA_WIDTH-1:0] display_ff, display_in;
   logic [DATA_WIDTH-1:0] result_ff, result_in;
   logic [DATA_WIDTH-1:0] memory_ff, memory_in;
   kcc_pkg::pend_type     pending_ff, pending_in;
   logic                  error_ff, error_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]    rsp_display_ff, rsp_memory_ff;
   logic                  rsp_error_ff;
   logic                  rsp_load;

   kcc_pkg::unit_ctl_type unit_ctl;
   logic                  unit_done;
   logic [DATA_WIDTH-1:0] unit_result;

   logic                  eq_finish;
   logic [DATA_WIDTH-1:0] eq_value;
   logic                  eq_div_ok;

   logic                  req_fire;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_load  = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   kcc_muldiv #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .ctl    (unit_ctl),
      .opnd_a (result_ff),
      .opnd_b (display_ff),
      .done   (unit_done),
      .result (unit_result)
   );

   always_comb begin
      state_in    = state_ff;
      mode_in     = mode_ff;
      digit_in    = digit_ff;
      opc_in      = opc_ff;
      display_in  = display_ff;
      result_in   = result_ff;
      memory_in   = memory_ff;
      pending_in  = pending_ff;
      error_in    = error_ff;
      unit_ctl    = '0;
      eq_finish   = 1'b0;
      eq_value    = display_ff;
      eq_div_ok   = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               mode_in  = req_mode;
               digit_in = req_digit_value;
               opc_in   = req_operator_code;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_DONE;
            case (mode_ff)
               kcc_pkg::KEY_DIGIT: begin
                  // display * 10 as (display << 3) + (display << 1)
                  display_in = (display_ff << 3) + (display_ff << 1)
                               + DATA_WIDTH'(digit_ff);
               end
               kcc_pkg::KEY_OPER, kcc_pkg::KEY_EQUALS: begin
                  if (mode_ff == kcc_pkg::KEY_OPER && pending_ff == kcc_pkg::PEND_NONE) begin
                     result_in  = display_ff;
                     pending_in = kcc_pkg::pend_of_op(opc_ff);
                     display_in = '0;
                  end else begin
                     unique case (pending_ff)
                        kcc_pkg::PEND_ADD: begin
                           eq_finish = 1'b1;
                           eq_value  = result_ff + display_ff;
                        end
                        kcc_pkg::PEND_SUB: begin
                           eq_finish = 1'b1;
                           eq_value  = result_ff - display_ff;
                        end
                        kcc_pkg::PEND_MUL: begin
                           unit_ctl.start = 1'b1;
                           state_in       = S_WAIT;
                        end
                        kcc_pkg::PEND_DIV: begin
                           if (display_ff == '0) begin
                              // divide by zero: flag and clear
                              eq_finish = 1'b1;
                              eq_value  = '0;
                              error_in  = 1'b1;
                           end else begin
                              unit_ctl.start  = 1'b1;
                              unit_ctl.is_div = 1'b1;
                              state_in        = S_WAIT;
                           end
                        end
                        default: begin
                           eq_finish = 1'b1;
                           eq_value  = display_ff;
                        end
                     endcase
                  end
               end
               kcc_pkg::KEY_MADD: begin
                  memory_in = memory_ff + display_ff;
                  error_in  = 1'b0;
               end
               kcc_pkg::KEY_MCLEAR: begin
                  memory_in = '0;
                  error_in  = 1'b0;
               end
               kcc_pkg::KEY_MRECALL: begin
                  display_in = memory_ff;
                  error_in   = 1'b0;
               end
               kcc_pkg::KEY_ALLCLEAR: begin
                  display_in = '0;
                  result_in  = '0;
                  memory_in  = '0;
                  pending_in = kcc_pkg::PEND_NONE;
                  error_in   = 1'b0;
               end
               default: begin
               end
            endcase
         end
         S_WAIT: begin
            if (unit_done) begin
               eq_finish = 1'b1;
               eq_value  = unit_result;
               eq_div_ok = (pending_ff == kcc_pkg::PEND_DIV);
               state_in  = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // common tail of equals, and the operator that follows it
      if (eq_finish) begin
         result_in  = eq_value;
         display_in = eq_value;
         pending_in = kcc_pkg::PEND_NONE;
         if (eq_div_ok) begin
            error_in = 1'b0;
         end
         if (mode_ff == kcc_pkg::KEY_OPER) begin
            pending_in = kcc_pkg::pend_of_op(opc_ff);
            display_in = '0;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         display_ff   <= '0;
         result_ff    <= '0;
         memory_ff    <= '0;
         pending_ff   <= kcc_pkg::PEND_NONE;
         error_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         display_ff   <= display_in;
         result_ff    <= result_in;
         memory_ff    <= memory_in;
         pending_ff   <= pending_in;
         error_ff     <= error_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff  <= mode_in;
      digit_ff <= digit_in;
      opc_ff   <= opc_in;
      if (rsp_load) begin
         // sign-extend or truncate to the output word width
         rsp_display_ff <= kcc_pkg::OUT_WIDTH'(signed'(display_ff));
         rsp_memory_ff  <= kcc_pkg::OUT_WIDTH'(signed'(memory_ff));
         rsp_error_ff   <= error_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_display_value = rsp_display_ff;
   assign rsp_memory_value  = rsp_memory_ff;
   assign rsp_error_flag    = rsp_error_ff;

   `KCC_ASSERT(a_start_in_exec, clock, reset, unit_ctl.start |-> state_ff == S_EXEC, "unit started outside exec")
   `KCC_ASSERT(a_done_in_wait, clock, reset, unit_done |-> state_ff == S_WAIT, "unit finished while not waiting")
   `KCC_ASSERT(a_busy_after_accept, clock, reset, req_fire |=> !req_ready, "core took a key while busy")
   `KCC_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> (!rsp_valid && state_ff == S_IDLE), "reset left state")

endmodule

`default_nettype wire

[tb/keypad_calculator_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_calculator_core_tb
// Self-checking bench for the four-function keypad calculator core.
// ----------------------------------------------------------------------------
// A short scripted key sequence covers every key kind, every operator,
// digits above nine, the ignored key code, divide by zero, the most negative
// value divided by minus one and error persistence. A long run of random key
// sequences follows. Each status word from the core is compared field by
// field against a local calculator model, with random gaps and stalls on
// both handshakes.
// ----------------------------------------------------------------------------

module keypad_calculator_core_tb;

   localparam logic [2:0] KEY_UNUSED = 3'd7;
   localparam int         RANDOM_KEYS = 1250;
   localparam int         SCRIPT_LEN = 26;

   typedef struct packed {
      logic [31:0] display;
      logic [31:0] memory;
      logic        error;
   } status_word_type;

   typedef struct packed {
      logic [2:0]      mode;
      logic [3:0]      digit;
      logic [1:0]      opc;
      logic            typed;
      status_word_type word;
   } key_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_mode = kcc_pkg::KEY_ALLCLEAR;
   logic [3:0]  req_digit_value = 4'd0;
   logic [1:0]  req_operator_code = kcc_pkg::OP_ADD;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic signed [31:0] rsp_display_value;
   logic signed [31:0] rsp_memory_value;
   logic        rsp_error_flag;

   // calculator model state
   logic signed [31:0] calc_display;
   logic signed [31:0] calc_result;
   logic signed [31:0] calc_memory;
   kcc_pkg::pend_type  calc_pending;
   logic               calc_error;

   status_word_type expected_words[$];
   key_row_type     key_script [SCRIPT_LEN];
   int              mismatch_count = 0;
   bit              steady = 1'b0;
   int              ready_hold = 0;

   keypad_calculator_core u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_digit_value   (req_digit_value),
      .req_operator_code (req_operator_code),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_display_value (rsp_display_value),
      .rsp_memory_value  (rsp_memory_value),
      .rsp_error_flag    (rsp_error_flag)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // mostly short idle stretches, now and then a long one
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      else if (r < 95) return $urandom_range(4, 12);
      else return $urandom_range(20, 80);
   endfunction

   task automatic note_mismatch(input string field, input logic [31:0] got,
                                input logic [31:0] want);
      $display("%0t: %s got %h want %h", $time, field, got, want);
      mismatch_count++;
   endtask

   task automatic calc_clear();
      calc_display = '0;
      calc_result  = '0;
      calc_memory  = '0;
      calc_pending = kcc_pkg::PEND_NONE;
      calc_error   = 1'b0;
   endtask

   // equals: fold the display into the result with the pending operator
   task automatic calc_equals();
      logic signed [63:0] num;
      logic signed [63:0] den;
      logic signed [63:0] quo;
      case (calc_pending)
         kcc_pkg::PEND_ADD: calc_result = calc_result + calc_display;
         kcc_pkg::PEND_SUB: calc_result = calc_result - calc_display;
         kcc_pkg::PEND_MUL: calc_result = calc_result * calc_display;
         kcc_pkg::PEND_DIV: begin
            if (calc_display == 0) begin
               calc_error  = 1'b1;
               calc_result = '0;
            end else begin
               // widened so that most negative over minus one wraps cleanly
               num = 64'(calc_result);
               den = 64'(calc_display);
               quo = num / den;
               calc_result = quo[31:0];
               calc_error  = 1'b0;
            end
         end
         default: calc_result = calc_display;
      endcase
      calc_display = calc_result;
      calc_pending = kcc_pkg::PEND_NONE;
   endtask

   task automatic press_key(input logic [2:0] m, input logic [3:0] d,
                            input logic [1:0] o, output status_word_type word);
      case (m)
         kcc_pkg::KEY_DIGIT:
            calc_display = calc_display * 32'sd10 + $signed({28'd0, d});
         kcc_pkg::KEY_OPER: begin
            if (calc_pending != kcc_pkg::PEND_NONE) calc_equals();
            else calc_result = calc_display;
            case (o)
               kcc_pkg::OP_ADD: calc_pending = kcc_pkg::PEND_ADD;
               kcc_pkg::OP_SUB: calc_pending = kcc_pkg::PEND_SUB;
               kcc_pkg::OP_MUL: calc_pending = kcc_pkg::PEND_MUL;
               default:         calc_pending = kcc_pkg::PEND_DIV;
            endcase
            calc_display = '0;
         end
         kcc_pkg::KEY_EQUALS: calc_equals();
         kcc_pkg::KEY_MADD: begin
            calc_memory = calc_memory + calc_display;
            calc_error  = 1'b0;
         end
         kcc_pkg::KEY_MCLEAR: begin
            calc_memory = '0;
            calc_error  = 1'b0;
         end
         kcc_pkg::KEY_MRECALL: begin
            calc_display = calc_memory;
            calc_error   = 1'b0;
         end
         kcc_pkg::KEY_ALLCLEAR: calc_clear();
         default: ;
      endcase
      word.display = calc_display;
      word.memory  = calc_memory;
      word.error   = calc_error;
   endtask

   // drive one key word at the falling edge and hold it until taken
   task automatic accept_key(input logic [2:0] m, input logic [3:0] d,
                             input logic [1:0] o);
      int gap;
      gap = (steady || $urandom_range(0, 99) < 50) ? 0 : idle_len();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_mode          <= m;
      req_digit_value   <= d;
      req_operator_code <= o;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // random key with valid key codes and decimal digits dominating
   task automatic pick_key(output logic [2:0] m, output logic [3:0] d,
                           output logic [1:0] o);
      int r;
      r = $urandom_range(0, 99);
      d = 4'($urandom_range(0, 15));
      o = 2'($urandom_range(0, 3));
      if (r < 45) begin
         m = kcc_pkg::KEY_DIGIT;
         if ($urandom_range(0, 99) < 88) d = 4'($urandom_range(0, 9));
      end
      else if (r < 66) m = kcc_pkg::KEY_OPER;
      else if (r < 78) m = kcc_pkg::KEY_EQUALS;
      else if (r < 83) m = kcc_pkg::KEY_MADD;
      else if (r < 87) m = kcc_pkg::KEY_MCLEAR;
      else if (r < 92) m = kcc_pkg::KEY_MRECALL;
      else if (r < 95) m = kcc_pkg::KEY_ALLCLEAR;
      else m = KEY_UNUSED;
   endtask

   always @(negedge clock) begin
      if (ready_hold > 0) begin
         ready_hold--;
      end else if (steady) begin
         rsp_ready <= 1'b1;
      end else if ($urandom_range(0, 99) < 60) begin
         rsp_ready <= 1'b1;
         ready_hold = $urandom_range(0, 7);
      end else begin
         rsp_ready <= 1'b0;
         ready_hold = idle_len() - 1;
      end
   end

   always @(posedge clock) begin
      status_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            note_mismatch("unexpected word, display", rsp_display_value, '0);
         end else begin
            want = expected_words.pop_front();
            if (rsp_display_value !== want.display)
               note_mismatch("display", rsp_display_value, want.display);
            if (rsp_memory_value !== want.memory)
               note_mismatch("memory", rsp_memory_value, want.memory);
            if (rsp_error_flag !== want.error)
               note_mismatch("error", {31'd0, rsp_error_flag}, {31'd0, want.error});
         end
      end
   end

   initial begin
      #30_000_000;
      $display("keypad_calculator_core: mismatch");
      $finish;
   end

   initial begin
      status_word_type word;
      logic [2:0]      m;
      logic [3:0]      d;
      logic [1:0]      o;
      int              keys_sent;

      key_script = '{
         '{kcc_pkg::KEY_ALLCLEAR, 4'd0,  kcc_pkg::OP_ADD, 1'b1,
           '{32'd0, 32'd0, 1'b0}},
         '{kcc_pkg::KEY_OPER,     4'd0,  kcc_pkg::OP_SUB, 1'b1,
           '{32'd0, 32'd0, 1'b0}},
         '{kcc_pkg::KEY_DIGIT,    4'd1,  kcc_pkg::OP_ADD, 1'b1,
           '{32'd1, 32'd0, 1'b0}},
         '{kcc_pkg::KEY_EQUALS,   4'd0,  kcc_pkg::OP_ADD, 1'b1,
           '{32'hffffffff, 32'd0, 1'b0}},
         '{kcc_pkg::KEY_MADD,     4'd0,  kcc_pkg::OP_ADD, 1'b1,
           '{32'hffffffff, 32'hffffffff, 1'b0}},
         '{kcc_pkg::KEY_OPER,     4'd0,  kcc_pkg::OP_MUL, 1'b1,
           '{32'd0, 32'hffffffff, 1'b0}},
         // 2147483648 keyed in, wraps to the most negative value
         '{kcc_pkg::KEY_DIGIT,    4'd2,  kcc_pkg::OP_ADD, 1'b0, '0},
         '{kcc_pkg::KEY_DIGIT,    4'd1,  kcc_pkg::OP_ADD, 1'b0, '0},
         '{kcc_pkg::KEY_DIGIT,    4'd4,  kcc_pkg::OP_ADD, 1'b0, '0},
         '{kcc_pkg::KEY_DIGIT,    4'd7,  kcc_pkg::OP_ADD, 1'b0, '0},
         '{kcc_pkg::KEY_DIGIT,    4'd4,  kcc_pkg::OP_ADD, 1'b0, '0},
         '{kcc_pkg::KEY_DIGIT,    4'd8,  kcc_pkg::OP_ADD, 1'b0, '0},
         '{kcc_pkg::KEY_DIGIT,    4'd3,  kcc_pkg::OP_ADD, 1'b0, '0},
         '{kcc_pkg::KEY_DIGIT,    4'd6,  kcc_pkg::OP_ADD, 1'b0, '0},
         '{kcc_pkg::KEY_DIGIT,    4'd4,  kcc_pkg::OP_ADD, 1'b0, '0},
         '{kcc_pkg::KEY_DIGIT,    4'd8,  kcc_pkg::OP_ADD, 1'b0, '0},
         // minus one times most negative, then divided by minus one
         '{kcc_pkg::KEY_OPER,     4'd0,  kcc_pkg::OP_DIV, 1'b1,
           '{32'd0, 32'hffffffff, 1'b0}},
         '{kcc_pkg::KEY_MRECALL,  4'd0,  kcc_pkg::OP_ADD, 1'b1,
           '{32'hffffffff, 32'hffffffff, 1'b0}},
         '{kcc_pkg::KEY_EQUALS,   4'd0,  kcc_pkg::OP_ADD, 1'b1,
           '{32'h80000000, 32'hffffffff, 1'b0}},
         '{kcc_pkg::KEY_DIGIT,    4'd15, kcc_pkg::OP_ADD, 1'b0, '0},
         '{KEY_UNUSED,            4'd15, kcc_pkg::OP_DIV, 1'b0, '0},
         // divide by zero, error survives a digit, memory key clears it
         '{kcc_pkg::KEY_OPER,     4'd0,  kcc_pkg::OP_DIV, 1'b0, '0},
         '{kcc_pkg::KEY_EQUALS,   4'd0,  kcc_pkg::OP_ADD, 1'b1,
           '{32'd0, 32'hffffffff, 1'b1}},
         '{kcc_pkg::KEY_DIGIT,    4'd0,  kcc_pkg::OP_ADD, 1'b0, '0},
         '{kcc_pkg::KEY_MCLEAR,   4'd0,  kcc_pkg::OP_ADD, 1'b1,
           '{32'd0, 32'd0, 1'b0}},
         '{kcc_pkg::KEY_OPER,     4'd0,  kcc_pkg::OP_ADD, 1'b0, '0}
      };

      calc_clear();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < SCRIPT_LEN; i++) begin
         accept_key(key_script[i].mode, key_script[i].digit, key_script[i].opc);
         press_key(key_script[i].mode, key_script[i].digit, key_script[i].opc, word);
         if (key_script[i].typed) expected_words.push_back(key_script[i].word);
         else expected_words.push_back(word);
      end

      keys_sent = 0;
      while (keys_sent < RANDOM_KEYS) begin
         // every fourth block of words runs with no gaps on either side
         steady = ((keys_sent / 100) % 4) == 3;
         pick_key(m, d, o);
         accept_key(m, d, o);
         press_key(m, d, o, word);
         expected_words.push_back(word);
         if (m != KEY_UNUSED) keys_sent++;
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("keypad_calculator_core: match");
      end else begin
         $display("keypad_calculator_core: mismatch");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+hdl
hdl/kcc_pkg.sv
hdl/kcc_muldiv.sv
hdl/keypad_calculator_core.sv
tb/keypad_calculator_core_tb.sv
